[rtl/assert_macros.svh]
// Assertion macros for the flag overlay table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/lwwf_pkg.sv]
// Shared types and constants for the flag overlay table
`timescale 1ns / 1ps
package lwwf_pkg;

    localparam int LWWF_TABLE_ENTRIES = 256;
    localparam int LWWF_QUEUE_DEPTH   = 2;
    localparam int KEY_HALF_W         = 64;

    // Request codes on the input word
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_CLEAR,
        OP_NOP
    } t_op;

    // Classified word handed from the front to the back
    typedef struct packed {
        t_op                   op;
        logic [KEY_HALF_W-1:0] key_high;
        logic [KEY_HALF_W-1:0] key_low;
        logic                  flag;
    } t_cmd;

endpackage

[rtl/lwwf_front.sv]
// Front end: accepts input words, decodes the request and queues them
`timescale 1ns / 1ps
module lwwf_front #(
    parameter int QUEUE_DEPTH = lwwf_pkg::LWWF_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_req_type,
    input  logic [lwwf_pkg::KEY_HALF_W-1:0] i_key_high,
    input  logic [lwwf_pkg::KEY_HALF_W-1:0] i_key_low,
    input  logic                           i_flag_in,
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_pop,
    output lwwf_pkg::t_cmd                 o_cmd
);
    import lwwf_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_queue [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_fill;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_fill;
    t_op           w_op;
    t_cmd          w_cmd;
    logic          w_push;
    logic          w_pop;

    // Decode the request code
    always_comb begin
        unique case (i_req_type)
            REQ_INSERT: w_op = OP_INSERT;
            REQ_LOOKUP: w_op = OP_LOOKUP;
            REQ_CLEAR:  w_op = OP_CLEAR;
            default:    w_op = OP_NOP;
        endcase
    end

    assign w_cmd       = '{op: w_op, key_high: i_key_high, key_low: i_key_low, flag: i_flag_in};
    assign o_ready     = (r_fill != CW'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    // Hold pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

[rtl/lwwf_engine.sv]
// Back end: scans the key table with one comparator and updates it
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lwwf_engine #(
    parameter int TABLE_ENTRIES = lwwf_pkg::LWWF_TABLE_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  lwwf_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_flag_out,
    output logic           o_hit,
    output logic           o_status
);
    import lwwf_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef struct packed {
        logic [KEY_HALF_W-1:0] key_high;
        logic [KEY_HALF_W-1:0] key_low;
        logic                  flag;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_entry        r_mem [TABLE_ENTRIES];
    t_entry        r_rd_data;
    t_state        r_state;
    t_state        n_state;
    t_cmd          r_cmd;
    t_cmd          n_cmd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] n_addr;
    logic          r_pend;
    logic          n_pend;
    logic [AW-1:0] r_pidx;
    logic [AW-1:0] n_pidx;
    logic          r_flag_out;
    logic          n_flag_out;
    logic          r_hit;
    logic          n_hit;
    logic          r_status;
    logic          n_status;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    logic          w_match;
    logic          w_full;

    assign w_match   = r_pend && (r_rd_data.key_high == r_cmd.key_high)
                                && (r_rd_data.key_low == r_cmd.key_low);
    assign w_full    = (r_count == CW'(TABLE_ENTRIES));
    assign w_wr_data = '{key_high: r_cmd.key_high, key_low: r_cmd.key_low, flag: r_cmd.flag};
    assign o_valid   = (r_state == S_RESP);
    assign o_flag_out = r_flag_out;
    assign o_hit      = r_hit;
    assign o_status   = r_status;

    // Sequence one word: take it, scan the filled slots (insert or lookup), resolve, present
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pend     = 1'b0;
        n_pidx     = r_pidx;
        n_flag_out = r_flag_out;
        n_hit      = r_hit;
        n_status   = r_status;
        o_cmd_pop  = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_pidx;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_cmd      = i_cmd;
                    n_addr     = '0;
                    n_flag_out = 1'b0;
                    n_hit      = 1'b0;
                    n_status   = 1'b0;
                    unique case (i_cmd.op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_RESP;
                        end
                        OP_NOP: begin
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    // Key present: overwrite its flag or report it
                    n_hit   = 1'b1;
                    n_state = S_RESP;
                    if (r_cmd.op == OP_INSERT) begin
                        w_wr_en = 1'b1;
                    end else begin
                        n_flag_out = r_rd_data.flag;
                    end
                end else if (!r_pend && (r_addr == r_count)) begin
                    // Key absent: append, drop on full, or pass flag through
                    n_state = S_RESP;
                    if (r_cmd.op == OP_INSERT) begin
                        if (w_full) begin
                            n_status = 1'b1;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_count[AW-1:0];
                            n_count   = r_count + 1'b1;
                        end
                    end else begin
                        n_flag_out = r_cmd.flag;
                    end
                end else if (r_addr != r_count) begin
                    // Issue the next slot read
                    n_pend = 1'b1;
                    n_pidx = r_addr[AW-1:0];
                    n_addr = r_addr + 1'b1;
                end
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, scan position and the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_pidx     <= n_pidx;
        r_flag_out <= n_flag_out;
        r_hit      <= n_hit;
        r_status   <= n_status;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[r_addr[AW-1:0]];
    end

    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_ENTRIES))
    `ASSERT_IMPLIES(a_pend_in_fill, i_clk, i_rst_n, r_pend, {1'b0, r_pidx} < r_count)
    `ASSERT_IMPLIES(a_drop_no_hit, i_clk, i_rst_n, o_valid && r_status, !r_hit && !r_flag_out)
    `ASSERT_NEXT(a_drop_keeps_count, i_clk, i_rst_n, (r_state == S_SCAN) && w_full,
                 r_count == CW'(TABLE_ENTRIES))

endmodule

[rtl/last_write_wins_flag_overlay_table_unit.sv]
// Top level of the last-write-wins flag overlay table
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   request  | i_valid / o_ready    | i_req_type, i_key_high, i_key_low, i_flag_in
//   result   | o_valid / i_ready    | o_flag_out, o_hit, o_status
//
// An insert or lookup scans the filled slots, at most TABLE_ENTRIES of them;
// a clear or unknown request skips the scan and goes straight to the result.
// The single-port table scan compares one slot per cycle.
// Reset empties the table at once through the fill count; no sweep is needed.
// A two-word queue keeps taking requests while a result waits on i_ready.
`timescale 1ns / 1ps
module last_write_wins_flag_overlay_table_unit #(
    parameter int TABLE_ENTRIES = lwwf_pkg::LWWF_TABLE_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_req_type,
    input  logic [lwwf_pkg::KEY_HALF_W-1:0] i_key_high,
    input  logic [lwwf_pkg::KEY_HALF_W-1:0] i_key_low,
    input  logic                            i_flag_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_flag_out,
    output logic                            o_hit,
    output logic                            o_status
);
    import lwwf_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    // Accept and classify
    lwwf_front #(
        .QUEUE_DEPTH (LWWF_QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_key_high  (i_key_high),
        .i_key_low   (i_key_low),
        .i_flag_in   (i_flag_in),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    // Scan and update the table
    lwwf_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_flag_out  (o_flag_out),
        .o_hit       (o_hit),
        .o_status    (o_status)
    );

endmodule
